/* src/pcfd_pkg.sv */
// Shared types and constants for the filtered-derivative PID controller.
// No dependencies; every other file of the block refers to it by scoped names.
package pcfd_pkg;

	localparam int PADDR_W = 5;

	// clamp applied to the integrator state after each accumulate
	localparam logic [30:0] ISTATE_LIMIT = 31'd65536000;
	localparam logic [30:0] LIMIT_RESET  = 31'd65536000;

	// filter coefficient used when the register holds zero (1.0 in Q16.16)
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_FILTER_GAIN = 3'd3,
		REG_PROP_LIMIT  = 3'd4,
		REG_INTEG_LIMIT = 3'd5,
		REG_DERIV_LIMIT = 3'd6,
		REG_OUT_LIMIT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] setpoint;
		logic signed [31:0] position;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] p_term;
		logic signed [31:0] i_term;
		logic signed [31:0] d_term;
	} result_t;

	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integ_gain;
		logic signed [31:0] deriv_gain;
		logic signed [31:0] filter_gain;
		logic [30:0]        prop_limit;
		logic [30:0]        integ_limit;
		logic [30:0]        deriv_limit;
		logic [30:0]        out_limit;
	} cfg_t;

	// multiplier operand selects
	typedef enum logic [2:0] {
		MA_PROP,
		MA_INTEG,
		MA_DERIV,
		MA_FD,
		MA_FILT
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_ERR,
		MB_ISTATE,
		MB_FILT,
		MB_DIFF
	} mul_b_t;

	// datapath operations, one per microcode step
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_IACC,
		OP_PCLAMP,
		OP_ICLAMP,
		OP_FD,
		OP_DFS,
		OP_DCLAMP,
		OP_DZERO,
		OP_OUT
	} op_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		op_t    op;
	} ctrl_t;

	typedef struct packed {
		logic out_busy;
		logic dg_zero;
	} dp_stat_t;

endpackage

/* src/pid_controller_filtered_derivative.sv */
// Top level of the PID controller with anti-windup and filtered derivative.
// Depends on pcfd_pkg, pcfd_regs, pcfd_ucode and pcfd_dpath.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+---------------------------------
//  sample   | sample_valid / sample_stall     | setpoint, position (Q16.16)
//  result   | result_valid / result_stall     | drive, p_term, i_term, d_term
//  config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// All five products share one multiplier, and each product passes a multiply and a
// rounding register; with the derivative gain at zero the derivative steps are skipped.
// A new request is taken only at the idle step, once the previous one has left its
// output step.
// Reset clears the integrator and filter state and the step counter.
// A stalled result holds the program at its output step; a held result alone
// does not block the next request.
module pid_controller_filtered_derivative (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  pcfd_pkg::sample_t            sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output pcfd_pkg::result_t            result
);

	pcfd_pkg::cfg_t     cfg;
	pcfd_pkg::ctrl_t    ctrl;
	pcfd_pkg::dp_stat_t stat;

	pcfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcfd_ucode u_ucode (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.stat         (stat),
		.sample_stall (sample_stall),
		.ctrl         (ctrl)
	);

	pcfd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctrl         (ctrl),
		.sample       (sample),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.stat         (stat)
	);

endmodule

/* src/pcfd_regs.sv */
// APB-style configuration register file for the PID controller.
// Depends on pcfd_pkg for the register map and the cfg_t bundle.
module pcfd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output pcfd_pkg::cfg_t               cfg
);

	pcfd_pkg::cfg_t      cfg_q;
	pcfd_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign idx    = pcfd_pkg::reg_idx_t'(paddr[pcfd_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.filter_gain <= '0;
			cfg_q.prop_limit  <= pcfd_pkg::LIMIT_RESET;
			cfg_q.integ_limit <= pcfd_pkg::LIMIT_RESET;
			cfg_q.deriv_limit <= pcfd_pkg::LIMIT_RESET;
			cfg_q.out_limit   <= pcfd_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				pcfd_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= pwdata;
				pcfd_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain  <= pwdata;
				pcfd_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain  <= pwdata;
				pcfd_pkg::REG_FILTER_GAIN: cfg_q.filter_gain <= pwdata;
				pcfd_pkg::REG_PROP_LIMIT:  cfg_q.prop_limit  <= pwdata[30:0];
				pcfd_pkg::REG_INTEG_LIMIT: cfg_q.integ_limit <= pwdata[30:0];
				pcfd_pkg::REG_DERIV_LIMIT: cfg_q.deriv_limit <= pwdata[30:0];
				pcfd_pkg::REG_OUT_LIMIT:   cfg_q.out_limit   <= pwdata[30:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pcfd_pkg::REG_PROP_GAIN:   prdata = cfg_q.prop_gain;
			pcfd_pkg::REG_INTEG_GAIN:  prdata = cfg_q.integ_gain;
			pcfd_pkg::REG_DERIV_GAIN:  prdata = cfg_q.deriv_gain;
			pcfd_pkg::REG_FILTER_GAIN: prdata = cfg_q.filter_gain;
			pcfd_pkg::REG_PROP_LIMIT:  prdata = {1'b0, cfg_q.prop_limit};
			pcfd_pkg::REG_INTEG_LIMIT: prdata = {1'b0, cfg_q.integ_limit};
			pcfd_pkg::REG_DERIV_LIMIT: prdata = {1'b0, cfg_q.deriv_limit};
			pcfd_pkg::REG_OUT_LIMIT:   prdata = {1'b0, cfg_q.out_limit};
		endcase
	end

endmodule

/* src/pcfd_ucode.sv */
// Microcode sequencer: step counter, control-word ROM and next-step logic.
// Depends on pcfd_pkg for the control word fields sent to the datapath.
module pcfd_ucode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  pcfd_pkg::dp_stat_t stat,
	output logic               sample_stall,
	output pcfd_pkg::ctrl_t    ctrl
);

	typedef enum logic [1:0] {
		W_NONE,
		W_NO_REQ,
		W_OUT_BUSY
	} wait_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_ALWAYS,
		J_DG_ZERO
	} jump_t;

	typedef struct packed {
		wait_t           wait_on;
		jump_t           jump_on;
		logic [3:0]      target;
		pcfd_pkg::ctrl_t ctrl;
	} ucw_t;

	localparam logic [3:0] STEP_IDLE   = 4'd0;
	localparam logic [3:0] STEP_MUL_P  = 4'd1;
	localparam logic [3:0] STEP_MUL_I  = 4'd2;
	localparam logic [3:0] STEP_PTERM  = 4'd3;
	localparam logic [3:0] STEP_ITERM  = 4'd4;
	localparam logic [3:0] STEP_FD     = 4'd5;
	localparam logic [3:0] STEP_MUL_D  = 4'd6;
	localparam logic [3:0] STEP_FILT   = 4'd7;
	localparam logic [3:0] STEP_DTERM  = 4'd8;
	localparam logic [3:0] STEP_DZERO  = 4'd9;
	localparam logic [3:0] STEP_OUT    = 4'd10;

	// Each product passes the product register and then the round register, so each
	// clamp/update step consumes the rounded product of an earlier multiply step.
	function automatic ucw_t rom_word(input logic [3:0] step);
		ucw_t w;
		w.wait_on    = W_NONE;
		w.jump_on    = J_NONE;
		w.target     = STEP_IDLE;
		w.ctrl.mul_a = pcfd_pkg::MA_PROP;
		w.ctrl.mul_b = pcfd_pkg::MB_ERR;
		w.ctrl.op    = pcfd_pkg::OP_NOP;
		unique case (step)
			STEP_IDLE: begin
				w.wait_on = W_NO_REQ;
				w.ctrl.op = pcfd_pkg::OP_LOAD;
			end
			STEP_MUL_P: begin
				w.ctrl.op = pcfd_pkg::OP_IACC;
			end
			STEP_MUL_I: begin
				w.ctrl.mul_a = pcfd_pkg::MA_INTEG;
				w.ctrl.mul_b = pcfd_pkg::MB_ISTATE;
			end
			STEP_PTERM: begin
				w.ctrl.mul_a = pcfd_pkg::MA_DERIV;
				w.ctrl.mul_b = pcfd_pkg::MB_FILT;
				w.ctrl.op    = pcfd_pkg::OP_PCLAMP;
			end
			STEP_ITERM: begin
				w.jump_on = J_DG_ZERO;
				w.target  = STEP_DZERO;
				w.ctrl.op = pcfd_pkg::OP_ICLAMP;
			end
			STEP_FD: begin
				w.ctrl.mul_a = pcfd_pkg::MA_FILT;
				w.ctrl.mul_b = pcfd_pkg::MB_DIFF;
				w.ctrl.op    = pcfd_pkg::OP_FD;
			end
			STEP_MUL_D: begin
				w.ctrl.mul_a = pcfd_pkg::MA_FD;
				w.ctrl.mul_b = pcfd_pkg::MB_DIFF;
			end
			STEP_FILT: begin
				w.ctrl.op = pcfd_pkg::OP_DFS;
			end
			STEP_DTERM: begin
				w.jump_on = J_ALWAYS;
				w.target  = STEP_OUT;
				w.ctrl.op = pcfd_pkg::OP_DCLAMP;
			end
			STEP_DZERO: begin
				w.ctrl.op = pcfd_pkg::OP_DZERO;
			end
			STEP_OUT: begin
				w.wait_on = W_OUT_BUSY;
				w.jump_on = J_ALWAYS;
				w.target  = STEP_IDLE;
				w.ctrl.op = pcfd_pkg::OP_OUT;
			end
			default: begin
				w.jump_on = J_ALWAYS;
				w.target  = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [3:0] upc_q;
	logic [3:0] upc_d;
	ucw_t       cw;
	logic       waiting;
	logic       take_jump;

	assign cw = rom_word(upc_q);

	always_comb begin
		waiting   = ((cw.wait_on == W_NO_REQ) && !sample_valid) ||
		            ((cw.wait_on == W_OUT_BUSY) && stat.out_busy);
		take_jump = (cw.jump_on == J_ALWAYS) ||
		            ((cw.jump_on == J_DG_ZERO) && stat.dg_zero);
		if (waiting) begin
			upc_d = upc_q;
		end else if (take_jump) begin
			upc_d = cw.target;
		end else begin
			upc_d = upc_q + 4'd1;
		end
		ctrl = cw.ctrl;
		if (waiting) begin
			ctrl.op = pcfd_pkg::OP_NOP;
		end
	end

	assign sample_stall = (upc_q != STEP_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

`ifndef SYNTHESIS
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |-> (ctrl.op == pcfd_pkg::OP_LOAD))
		else $error("request accepted without a load step");

	a_upc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= STEP_OUT)
		else $error("step counter left the program");

	a_out_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == pcfd_pkg::OP_OUT) |=> (upc_q == STEP_IDLE))
		else $error("output step did not return to idle");
`endif

endmodule

/* src/pcfd_dpath.sv */
// Datapath: shared 32x33 multiplier, rounding stage, clamp/saturate unit,
// integrator and derivative filter state, and the result register.
// Depends on pcfd_pkg for the config bundle, control word and payload types.
module pcfd_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  pcfd_pkg::cfg_t     cfg,
	input  pcfd_pkg::ctrl_t    ctrl,
	input  pcfd_pkg::sample_t  sample,
	input  logic               result_stall,
	output logic               result_valid,
	output pcfd_pkg::result_t  result,
	output pcfd_pkg::dp_stat_t stat
);

	localparam logic signed [34:0] IST_HI35 = 35'(pcfd_pkg::ISTATE_LIMIT);
	localparam logic signed [33:0] IST_HI34 = 34'(pcfd_pkg::ISTATE_LIMIT);
	localparam logic signed [34:0] DIFF_HI  = 35'sd4294967295;
	localparam logic signed [48:0] S32_HI   = 49'sd2147483647;
	localparam logic signed [48:0] S32_LO   = -49'sd2147483648;
	localparam logic signed [49:0] ST34_HI  = 50'sd8589934591;
	localparam logic signed [49:0] ST34_LO  = -50'sd8589934592;

	// clamp v to [-lim, lim], result fits 32 bits signed
	function automatic logic signed [31:0] clamp_lim(input logic signed [49:0] v,
			input logic [30:0] lim);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = $signed({19'd0, lim});
		lo = -hi;
		if (v > hi) begin
			return hi[31:0];
		end else if (v < lo) begin
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	// item registers
	logic signed [31:0] pos_q;
	logic signed [32:0] err_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] fd_q;
	logic signed [31:0] p_q;
	logic signed [31:0] i_q;
	logic signed [31:0] d_q;
	logic signed [64:0] prod_q;
	logic signed [48:0] rnd_q;
	pcfd_pkg::result_t  result_q;

	// state
	logic signed [33:0] istate_q;
	logic signed [33:0] dfs_q;
	logic               result_valid_q;

	logic signed [31:0] filt;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] mul_res;
	logic signed [64:0] rnd_sum;
	logic signed [49:0] rnd50;
	logic signed [34:0] iacc_sum;
	logic signed [33:0] iacc_sat;
	logic signed [49:0] i_hi;
	logic               i_clip;
	logic signed [33:0] windup;
	logic signed [34:0] diff_raw;
	logic signed [32:0] diff_sat;
	logic signed [31:0] fd_sat;
	logic signed [49:0] dfs_sum;
	logic signed [33:0] dfs_sat;
	logic signed [49:0] sum3;

	assign filt = (cfg.filter_gain == '0) ? pcfd_pkg::ONE_Q16 : cfg.filter_gain;

	always_comb begin
		unique case (ctrl.mul_a)
			pcfd_pkg::MA_PROP:  mul_a = cfg.prop_gain;
			pcfd_pkg::MA_INTEG: mul_a = cfg.integ_gain;
			pcfd_pkg::MA_DERIV: mul_a = cfg.deriv_gain;
			pcfd_pkg::MA_FD:    mul_a = fd_q;
			pcfd_pkg::MA_FILT:  mul_a = filt;
			default:            mul_a = '0;
		endcase
		unique case (ctrl.mul_b)
			// state is already clamped to ISTATE_LIMIT here
			pcfd_pkg::MB_ERR:    mul_b = err_q;
			pcfd_pkg::MB_ISTATE: mul_b = istate_q[32:0];
			pcfd_pkg::MB_FILT:   mul_b = $signed({filt[31], filt});
			pcfd_pkg::MB_DIFF:   mul_b = diff_q;
			default:             mul_b = '0;
		endcase
	end

	assign mul_res = mul_a * mul_b;
	// round half up, then arithmetic shift by 16
	assign rnd_sum = prod_q + 65'sd32768;
	assign rnd50   = $signed({rnd_q[48], rnd_q});

	always_comb begin
		iacc_sum = $signed({istate_q[33], istate_q}) + $signed({{2{err_q[32]}}, err_q});
		if (iacc_sum > IST_HI35) begin
			iacc_sat = IST_HI35[33:0];
		end else if (iacc_sum < -IST_HI35) begin
			iacc_sat = -IST_HI34;
		end else begin
			iacc_sat = iacc_sum[33:0];
		end

		i_hi   = $signed({19'd0, cfg.integ_limit});
		i_clip = (rnd50 > i_hi) || (rnd50 < -i_hi);
		windup = istate_q - $signed({err_q[32], err_q});

		diff_raw = -$signed({{3{pos_q[31]}}, pos_q}) - $signed({dfs_q[33], dfs_q});
		if (diff_raw > DIFF_HI) begin
			diff_sat = DIFF_HI[32:0];
		end else if (diff_raw < -DIFF_HI) begin
			diff_sat = 33'(-DIFF_HI);
		end else begin
			diff_sat = diff_raw[32:0];
		end

		if (rnd_q > S32_HI) begin
			fd_sat = S32_HI[31:0];
		end else if (rnd_q < S32_LO) begin
			fd_sat = S32_LO[31:0];
		end else begin
			fd_sat = rnd_q[31:0];
		end

		dfs_sum = $signed({{16{dfs_q[33]}}, dfs_q}) + rnd50;
		if (dfs_sum > ST34_HI) begin
			dfs_sat = ST34_HI[33:0];
		end else if (dfs_sum < ST34_LO) begin
			dfs_sat = ST34_LO[33:0];
		end else begin
			dfs_sat = dfs_sum[33:0];
		end

		sum3 = $signed({{18{p_q[31]}}, p_q}) + $signed({{18{i_q[31]}}, i_q}) +
		       $signed({{18{d_q[31]}}, d_q});
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_res;
		rnd_q  <= rnd_sum[64:16];
		unique case (ctrl.op)
			pcfd_pkg::OP_LOAD: begin
				pos_q <= sample.position;
				err_q <= $signed({sample.setpoint[31], sample.setpoint}) -
				         $signed({sample.position[31], sample.position});
			end
			pcfd_pkg::OP_PCLAMP: p_q <= clamp_lim(rnd50, cfg.prop_limit);
			pcfd_pkg::OP_ICLAMP: begin
				i_q    <= clamp_lim(rnd50, cfg.integ_limit);
				diff_q <= diff_sat;
			end
			pcfd_pkg::OP_FD:     fd_q <= fd_sat;
			pcfd_pkg::OP_DCLAMP: d_q  <= clamp_lim(rnd50, cfg.deriv_limit);
			pcfd_pkg::OP_DZERO:  d_q  <= '0;
			pcfd_pkg::OP_OUT: begin
				result_q.drive  <= clamp_lim(sum3, cfg.out_limit);
				result_q.p_term <= p_q;
				result_q.i_term <= i_q;
				result_q.d_term <= d_q;
			end
			default: ;
		endcase
	end

	// controller state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			istate_q       <= '0;
			dfs_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == pcfd_pkg::OP_IACC) begin
				istate_q <= iacc_sat;
			end else if ((ctrl.op == pcfd_pkg::OP_ICLAMP) && i_clip) begin
				// anti-windup: back out this request's error
				istate_q <= windup;
			end
			if (ctrl.op == pcfd_pkg::OP_DFS) begin
				dfs_q <= dfs_sat;
			end
			if (ctrl.op == pcfd_pkg::OP_OUT) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign result        = result_q;
	assign stat.out_busy = result_valid_q && result_stall;
	assign stat.dg_zero  = (cfg.deriv_gain == '0);

`ifndef SYNTHESIS
	a_istate_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == pcfd_pkg::OP_IACC) |=> ((istate_q <= IST_HI34) && (istate_q >= -IST_HI34)))
		else $error("integrator state outside its limit after accumulate");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == pcfd_pkg::OP_OUT) |-> !(result_valid_q && result_stall))
		else $error("result register overwritten while held");

	a_filter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op != pcfd_pkg::OP_DFS) |=> $stable(dfs_q))
		else $error("filter state changed outside its update step");
`endif

endmodule

/* bench/tb_pid_controller_filtered_derivative.sv */
// Self-checking bench for pid_controller_filtered_derivative: drives requests and APB writes,
// predicts drive and the three clamped terms per request, and compares every result.
// Depends on pcfd_pkg and the RTL of the block only.
module tb_pid_controller_filtered_derivative;
	timeunit 1ns;
	timeprecision 1ps;

	import pcfd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_REQUESTS = 135;

	localparam longint ISTATE = longint'(ISTATE_LIMIT);
	localparam longint DIFF_MAX = 64'sd4294967295;
	localparam longint ST34_HI = 64'sd8589934591;
	localparam longint ST34_LO = -64'sd8589934592;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                sample_valid;
	logic                sample_stall;
	sample_t             sample_bus;
	logic                result_valid;
	logic                result_stall;
	result_t             result_bus;

	// predictor copy of the registers and of the two accumulators
	cfg_t    ctl_cfg;
	longint  integ_acc;
	longint  filt_acc;
	result_t pending_drive[$];
	result_t want;

	int      mismatches;
	bit      no_gap;
	bit      no_stall;
	int      hold_left;
	int      stall_cnt;
	longint  track_sp;
	longint  track_pos;

	pid_controller_filtered_derivative dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Q32.32 back to Q16.16, half rounds toward +inf
	function automatic longint q16_round(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic result_t predict_drive(sample_t s);
		longint  pos, err, f, p, it, d, diff, fd, sum;
		longint  pl, il, dl, ol;
		result_t r;
		pl = longint'(ctl_cfg.prop_limit);
		il = longint'(ctl_cfg.integ_limit);
		dl = longint'(ctl_cfg.deriv_limit);
		ol = longint'(ctl_cfg.out_limit);
		pos = longint'(s.position);
		err = longint'(s.setpoint) - pos;
		f = (ctl_cfg.filter_gain != 0) ? longint'(ctl_cfg.filter_gain) : longint'(ONE_Q16);

		p = clamp(q16_round(longint'(ctl_cfg.prop_gain) * err), -pl, pl);

		integ_acc = clamp(integ_acc + err, -ISTATE, ISTATE);
		it = q16_round(longint'(ctl_cfg.integ_gain) * integ_acc);
		if (it > il || it < -il) begin
			// anti-windup: the error of this request is backed out again
			it = clamp(it, -il, il);
			integ_acc = integ_acc - err;
		end

		if (ctl_cfg.deriv_gain != 0) begin
			diff = clamp(-pos - filt_acc, -DIFF_MAX, DIFF_MAX);
			fd = clamp(q16_round(longint'(ctl_cfg.deriv_gain) * f), S32_LO, S32_HI);
			d = clamp(q16_round(fd * diff), -dl, dl);
			filt_acc = clamp(filt_acc + q16_round(f * diff), ST34_LO, ST34_HI);
		end else begin
			d = 0;
		end

		sum = clamp(p + it + d, -ol, ol);
		r.drive = sum[31:0];
		r.p_term = p[31:0];
		r.i_term = it[31:0];
		r.d_term = d[31:0];
		return r;
	endfunction

	task automatic note_mismatch(string what, logic signed [31:0] exp_v, logic signed [31:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %0d (%h), got %0d (%h)", what, exp_v, exp_v, act_v, act_v);
	endtask

	// APB write followed by a readback of the same register
	task automatic set_register(reg_idx_t idx, logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] stored;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PROP_GAIN:   ctl_cfg.prop_gain = value;
			REG_INTEG_GAIN:  ctl_cfg.integ_gain = value;
			REG_DERIV_GAIN:  ctl_cfg.deriv_gain = value;
			REG_FILTER_GAIN: ctl_cfg.filter_gain = value;
			REG_PROP_LIMIT:  ctl_cfg.prop_limit = value[30:0];
			REG_INTEG_LIMIT: ctl_cfg.integ_limit = value[30:0];
			REG_DERIV_LIMIT: ctl_cfg.deriv_limit = value[30:0];
			REG_OUT_LIMIT:   ctl_cfg.out_limit = value[30:0];
			default: ;
		endcase
		stored = (idx >= REG_PROP_LIMIT) ? {1'b0, value[30:0]} : value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (readback !== stored)
			note_mismatch({"readback of ", idx.name()}, stored, readback);
	endtask

	task automatic send_sample(sample_t s);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_bus <= s;
		do @(posedge clk); while (sample_stall);
		pending_drive.push_back(predict_drive(s));
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic sample_t make_sample(logic [31:0] sp, logic [31:0] pos);
		sample_t s;
		s.setpoint = sp;
		s.position = pos;
		return s;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0, 1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			2: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hffff_ffff;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1, 2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			3: return $urandom;
			default: begin
				case ($urandom_range(0, 2))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	// bit 31 is random throughout: the register ignores it
	function automatic logic [31:0] rand_limit();
		logic [31:0] top;
		top = {1'($urandom_range(0, 1)), 31'd0};
		case ($urandom_range(0, 4))
			0: return top;
			1, 2: return top | $urandom_range(0, 32'h0100_0000);
			3: return $urandom;
			default: return top | 32'h7fff_ffff;
		endcase
	endfunction

	// mostly a loop that settles toward its setpoint, with noise requests in between
	function automatic sample_t next_sample();
		longint step;
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 15) == 0)
				track_sp = longint'(signed'(rand_word()));
			step = ((track_sp - track_pos) >>> 3) + longint'($urandom_range(0, 8192)) - 4096;
			track_pos = clamp(track_pos + step, S32_LO, S32_HI);
			return make_sample(track_sp[31:0], track_pos[31:0]);
		end
		return make_sample(rand_word(), rand_word());
	endfunction

	// gains all zero after reset: every term is zero, the integrator still runs
	task automatic test_reset_values();
		send_sample(make_sample(32'h7fff_ffff, 32'h8000_0000));
		send_sample(make_sample(32'h8000_0000, 32'h7fff_ffff));
		send_sample(make_sample(32'h0000_0000, 32'h0000_0000));
		drain_results();
	endtask

	// proportional clamp, integrator windup and back-out, filter gain zero as one
	task automatic test_extremes();
		set_register(REG_PROP_GAIN, 32'h7fff_ffff);
		set_register(REG_INTEG_GAIN, 32'h0001_0000);
		set_register(REG_DERIV_GAIN, 32'h8000_0000);
		set_register(REG_FILTER_GAIN, 32'h0000_0000);
		set_register(REG_PROP_LIMIT, 32'hffff_ffff);
		set_register(REG_INTEG_LIMIT, 32'h0001_0000);
		set_register(REG_DERIV_LIMIT, 32'h0000_0000);
		set_register(REG_OUT_LIMIT, 32'h7fff_ffff);
		send_sample(make_sample(32'h7fff_ffff, 32'h8000_0000));
		send_sample(make_sample(32'h7fff_ffff, 32'h8000_0000));
		send_sample(make_sample(32'h8000_0000, 32'h7fff_ffff));
		send_sample(make_sample(32'h0000_0000, 32'h0000_0001));
		send_sample(make_sample(32'hffff_ffff, 32'h0000_0000));
		send_sample(make_sample(32'h0001_0000, 32'h0000_8000));
		drain_results();
	endtask

	// saturating fd product, difference and filter state; then derivative off and on again
	task automatic test_filter_paths();
		set_register(REG_DERIV_GAIN, 32'h7fff_ffff);
		set_register(REG_FILTER_GAIN, 32'h7fff_ffff);
		set_register(REG_DERIV_LIMIT, 32'h7fff_ffff);
		set_register(REG_PROP_GAIN, 32'hffff_0000);
		set_register(REG_INTEG_GAIN, 32'h8000_0000);
		set_register(REG_PROP_LIMIT, 32'h0000_0000);
		set_register(REG_INTEG_LIMIT, 32'h7fff_ffff);
		set_register(REG_OUT_LIMIT, 32'h0001_2345);
		send_sample(make_sample(32'h0000_0000, 32'h7fff_ffff));
		send_sample(make_sample(32'h0000_0000, 32'h8000_0000));
		send_sample(make_sample(32'h0000_0000, 32'h8000_0000));
		send_sample(make_sample(32'h0000_0000, 32'h7fff_ffff));
		send_sample(make_sample(32'h0000_0000, 32'h0000_0000));
		drain_results();
		// filter state must hold while the derivative path is off
		set_register(REG_DERIV_GAIN, 32'h0000_0000);
		set_register(REG_FILTER_GAIN, 32'hffff_0000);
		send_sample(make_sample(32'h0000_0000, 32'h1234_5678));
		send_sample(make_sample(32'h0000_0000, 32'h8000_0000));
		drain_results();
		set_register(REG_DERIV_GAIN, 32'h0001_0000);
		send_sample(make_sample(32'h0000_0000, 32'h0000_0000));
		send_sample(make_sample(32'h0000_0000, 32'h0010_0000));
		drain_results();
	endtask

	task automatic test_random_settings();
		reg_idx_t r;
		logic [31:0] value;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			r = r.first();
			repeat (r.num()) begin
				if (ph == 0)
					value = (r >= REG_PROP_LIMIT) ? {1'($urandom_range(0, 1)), 31'd0} :
						rand_gain();
				else if (ph == 1)
					value = (r >= REG_PROP_LIMIT) ? 32'hffff_ffff :
						($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
				else
					value = (r >= REG_PROP_LIMIT) ? rand_limit() : rand_gain();
				set_register(r, value);
				r = r.next();
			end
			repeat (PHASE_REQUESTS) send_sample(next_sample());
		end
		drain_results();
	endtask

	// long receiver hold while requests keep coming, so the input side backs up
	task automatic test_backpressure();
		no_gap = 1'b1;
		hold_left = 300;
		repeat (16) send_sample(next_sample());
		no_gap = 1'b0;
		drain_results();
	endtask

	task automatic test_no_idle();
		no_gap = 1'b1;
		no_stall = 1'b1;
		repeat (40) send_sample(next_sample());
		no_gap = 1'b0;
		no_stall = 1'b0;
		drain_results();
	endtask

	// receiver: stall drawn per result, counted down only while a result is shown
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (result_valid && !result_stall)
				stall_cnt = no_stall ? 0 : $urandom_range(0, 11);
			if (stall_cnt > 0) begin
				if (result_valid)
					stall_cnt--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request pending: %h", result_bus);
			end else begin
				want = pending_drive.pop_front();
				if (result_bus.drive !== want.drive)
					note_mismatch("drive", want.drive, result_bus.drive);
				if (result_bus.p_term !== want.p_term)
					note_mismatch("p_term", want.p_term, result_bus.p_term);
				if (result_bus.i_term !== want.i_term)
					note_mismatch("i_term", want.i_term, result_bus.i_term);
				if (result_bus.d_term !== want.d_term)
					note_mismatch("d_term", want.d_term, result_bus.d_term);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		sample_bus = '0;
		result_stall = 1'b0;
		stall_cnt = 0;
		hold_left = 0;
		no_gap = 1'b0;
		no_stall = 1'b0;
		mismatches = 0;
		track_sp = 0;
		track_pos = 0;
		integ_acc = 0;
		filt_acc = 0;
		ctl_cfg = '0;
		ctl_cfg.prop_limit = LIMIT_RESET;
		ctl_cfg.integ_limit = LIMIT_RESET;
		ctl_cfg.deriv_limit = LIMIT_RESET;
		ctl_cfg.out_limit = LIMIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_extremes();
		test_filter_paths();
		test_random_settings();
		test_backpressure();
		test_no_idle();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_drive.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
src/pcfd_pkg.sv
src/pcfd_regs.sv
src/pcfd_ucode.sv
src/pcfd_dpath.sv
src/pid_controller_filtered_derivative.sv
bench/tb_pid_controller_filtered_derivative.sv
